// ===== hw/rtl/deadline_sorted_timeout_queue_macros.svh =====
// ----------------------------------------------------------------------------
// deadline sorted timeout queue assertion macros
// shared property shorthands for the queue checkers
// ----------------------------------------------------------------------------
`ifndef DEADLINE_SORTED_TIMEOUT_QUEUE_MACROS_SVH
`define DEADLINE_SORTED_TIMEOUT_QUEUE_MACROS_SVH

// same-cycle implication
`define DSTQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dstq assertion failed");

// next-cycle implication
`define DSTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dstq assertion failed");

`endif

// ===== hw/rtl/dstq_pkg.sv =====
// ----------------------------------------------------------------------------
// dstq_pkg
// types, codes and helpers of the deadline sorted timeout queue
// ----------------------------------------------------------------------------
package dstq_pkg;

    localparam int DEF_QUEUE_DEPTH  = 16;
    localparam int DEF_CONN_ID_BITS = 12;
    localparam int MAX_RESULTS      = 16;
    localparam int POP_W            = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W           = 32;
    localparam int TICKS_W          = 31;
    localparam int REQ_W            = 3;
    localparam int STATUS_W         = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK      = 3'd0,
        REQ_TIME_WAIT = 3'd1,
        REQ_FIN_WAIT  = 3'd2,
        REQ_REMOVE    = 3'd3,
        REQ_REAP      = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        REG_TIME_WAIT = 1'b0,
        REG_FIN_WAIT  = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_POP,
        OP_DROP,
        OP_INSERT
    } cell_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DROP,
        S_INSERT,
        S_REMOVE,
        S_REAP,
        S_TICK,
        S_NOP
    } state_t;

    typedef struct packed {
        cell_op_t           op;
        logic [TIME_W-1:0]  deadline;
    } cell_ctl_t;

    // wrapping compare: a is at or after b
    function automatic logic at_or_after(input logic [TIME_W-1:0] a,
                                         input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = a - b;
        return ~diff[TIME_W-1];
    endfunction

endpackage

// ===== hw/rtl/dstq_cell.sv =====
// ----------------------------------------------------------------------------
// dstq_cell
// one slot of the sorted queue: holds a deadline and a connection and
// shifts toward either neighbor on drop, pop and insert
// ----------------------------------------------------------------------------
module dstq_cell
    import dstq_pkg::*;
#(
    parameter int CONN_ID_BITS = DEF_CONN_ID_BITS
)
(
    input  logic                    clk,
    input  cell_ctl_t               ctl,
    input  logic [CONN_ID_BITS-1:0] ctl_conn,
    input  logic                    occ,
    input  logic [TIME_W-1:0]       left_deadline,
    input  logic [CONN_ID_BITS-1:0] left_conn,
    input  logic                    left_suffix,
    input  logic [TIME_W-1:0]       right_deadline,
    input  logic [CONN_ID_BITS-1:0] right_conn,
    input  logic                    seen_in,
    output logic                    seen_out,
    input  logic                    suffix_in,
    output logic                    suffix_out,
    output logic [TIME_W-1:0]       deadline,
    output logic [CONN_ID_BITS-1:0] conn
);

    logic [TIME_W-1:0]       deadline_reg;
    logic [TIME_W-1:0]       deadline_next;
    logic [CONN_ID_BITS-1:0] conn_reg;
    logic [CONN_ID_BITS-1:0] conn_next;
    logic                    match;
    logic                    ge;

    assign match      = occ && (conn_reg == ctl_conn);
    assign seen_out   = seen_in | match;
    assign ge         = occ && at_or_after(ctl.deadline, deadline_reg);
    assign suffix_out = ge | suffix_in;

    always_comb
    begin
        deadline_next = deadline_reg;
        conn_next     = conn_reg;
        case (ctl.op)
            OP_HOLD:
            begin
            end
            OP_POP:
            begin
                deadline_next = right_deadline;
                conn_next     = right_conn;
            end
            OP_DROP:
            begin
                if (seen_out)
                begin
                    deadline_next = right_deadline;
                    conn_next     = right_conn;
                end
            end
            OP_INSERT:
            begin
                if (!suffix_out)
                begin
                    if (left_suffix)
                    begin
                        deadline_next = ctl.deadline;
                        conn_next     = ctl_conn;
                    end
                    else
                    begin
                        deadline_next = left_deadline;
                        conn_next     = left_conn;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        conn_reg     <= conn_next;
    end

    assign deadline = deadline_reg;
    assign conn     = conn_reg;

endmodule

// ===== hw/rtl/deadline_sorted_timeout_queue.sv =====
// ----------------------------------------------------------------------------
// deadline_sorted_timeout_queue
// connection timeout queue kept in wrapping deadline order in a row of cells
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  s_*       in         tuser: req_type; tdata: conn_id, now_time
//  m_*       out        tuser: conn_valid; tlast: last; tdata: out_conn_id,
//                       status, timer_armed, timer_deadline, queue_count
//  cfg_*     in         cfg_addr: register index; cfg_data: interval
//
//  after acceptance, remove, reap, unknown requests and a tick with nothing due take one pass,
//  enter requests a drop pass then an insert pass, a tick popping n entries one pass each
//  every pass is one shift of the whole cell row, one pass per cycle unless output stalls
//  results wait in one output register; a stalled output holds the row
//  reset empties the queue and clears both intervals; cell contents need none
// ----------------------------------------------------------------------------
module deadline_sorted_timeout_queue
    import dstq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int CONN_ID_BITS = DEF_CONN_ID_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [REQ_W-1:0]      s_tuser,   // req_type
    // conn_id, now_time
    input  logic [(((CONN_ID_BITS + TIME_W) + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_tuser,   // conn_valid
    output logic                  m_tlast,
    // out_conn_id, status, timer_armed, timer_deadline, queue_count
    output logic [(((CONN_ID_BITS + STATUS_W + 1 + TIME_W + $clog2(QUEUE_DEPTH + 1))
                    + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_addr,
    input  logic [TICKS_W-1:0]    cfg_data
);

    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_RAW = CONN_ID_BITS + STATUS_W + 1 + TIME_W + CNT_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CONN_ID_BITS-1:0] req_conn_reg, req_conn_next;
    logic [TIME_W-1:0]       now_reg, now_next;
    logic [TIME_W-1:0]       new_dl_reg, new_dl_next;
    logic [POP_W-1:0]        pop_cnt_reg, pop_cnt_next;
    logic [TICKS_W-1:0]      time_wait_reg, fin_wait_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [CONN_ID_BITS-1:0] out_conn_reg;
    logic                    out_flag_reg;
    logic                    out_last_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic                    out_armed_reg;
    logic [TIME_W-1:0]       out_deadline_reg;
    logic [CNT_W-1:0]        out_count_reg;

    logic                    emit;
    logic [CONN_ID_BITS-1:0] e_conn;
    logic                    e_flag;
    logic                    e_last;
    status_t                 e_status;
    logic [CNT_W-1:0]        e_cnt;
    logic [TIME_W-1:0]       e_head;

    cell_ctl_t               ctl;
    cell_op_t                ctl_op;
    logic                    slot_free;
    logic                    pop_cond;
    logic                    next_cond;
    logic                    found;
    logic [REQ_W-1:0]        in_req;
    logic [CONN_ID_BITS-1:0] in_conn;
    logic [TIME_W-1:0]       in_now;

    logic [TIME_W-1:0]       cell_deadline [QUEUE_DEPTH];
    logic [CONN_ID_BITS-1:0] cell_conn     [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]  occ;
    logic [QUEUE_DEPTH:0]    seen_chain;
    logic [QUEUE_DEPTH:0]    suffix_chain;

    assign in_req  = s_tuser;
    assign in_conn = s_tdata[CONN_ID_BITS-1:0];
    assign in_now  = s_tdata[CONN_ID_BITS +: TIME_W];

    assign seen_chain[0]            = 1'b0;
    assign suffix_chain[QUEUE_DEPTH] = 1'b0;
    assign ctl                      = {ctl_op, new_dl_reg};

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++)
        begin : g_cell
            logic [TIME_W-1:0]       l_dl, r_dl;
            logic [CONN_ID_BITS-1:0] l_c, r_c;
            logic                    l_suf;

            assign occ[k] = (CNT_W'(k) < count_reg);

            if (k == 0)
            begin : g_head
                assign l_dl  = '0;
                assign l_c   = '0;
                assign l_suf = 1'b1;
            end
            else
            begin : g_body
                assign l_dl  = cell_deadline[k-1];
                assign l_c   = cell_conn[k-1];
                assign l_suf = suffix_chain[k-1];
            end

            if (k == QUEUE_DEPTH - 1)
            begin : g_tail
                assign r_dl = '0;
                assign r_c  = '0;
            end
            else
            begin : g_mid
                assign r_dl = cell_deadline[k+1];
                assign r_c  = cell_conn[k+1];
            end

            dstq_cell #(
                .CONN_ID_BITS (CONN_ID_BITS)
            ) u_cell (
                .clk            (clk),
                .ctl            (ctl),
                .ctl_conn       (req_conn_reg),
                .occ            (occ[k]),
                .left_deadline  (l_dl),
                .left_conn      (l_c),
                .left_suffix    (l_suf),
                .right_deadline (r_dl),
                .right_conn     (r_c),
                .seen_in        (seen_chain[k]),
                .seen_out       (seen_chain[k+1]),
                .suffix_in      (suffix_chain[k+1]),
                .suffix_out     (suffix_chain[k]),
                .deadline       (cell_deadline[k]),
                .conn           (cell_conn[k])
            );
        end
    endgenerate

    assign found     = seen_chain[QUEUE_DEPTH];
    assign slot_free = !out_valid_reg || m_tready;
    assign pop_cond  = (count_reg != '0) && (pop_cnt_reg < POP_W'(MAX_RESULTS))
                       && at_or_after(now_reg, cell_deadline[0]);
    assign next_cond = (count_reg > CNT_W'(1))
                       && ((pop_cnt_reg + POP_W'(1)) < POP_W'(MAX_RESULTS))
                       && at_or_after(now_reg, cell_deadline[1]);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        req_conn_next = req_conn_reg;
        now_next      = now_reg;
        new_dl_next   = new_dl_reg;
        pop_cnt_next  = pop_cnt_reg;
        ctl_op        = OP_HOLD;
        s_tready      = 1'b0;
        emit          = 1'b0;
        e_conn        = '0;
        e_flag        = 1'b0;
        e_last        = 1'b1;
        e_status      = STATUS_OK;
        e_cnt         = count_reg;
        e_head        = cell_deadline[0];
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    req_conn_next = in_conn;
                    now_next      = in_now;
                    pop_cnt_next  = '0;
                    if (in_req == REQ_FIN_WAIT)
                        new_dl_next = in_now + {1'b0, fin_wait_reg};
                    else
                        new_dl_next = in_now + {1'b0, time_wait_reg};
                    case (in_req)
                        REQ_TICK:      state_next = S_TICK;
                        REQ_TIME_WAIT: state_next = S_DROP;
                        REQ_FIN_WAIT:  state_next = S_DROP;
                        REQ_REMOVE:    state_next = S_REMOVE;
                        REQ_REAP:      state_next = S_REAP;
                        default:       state_next = S_NOP;
                    endcase
                end
            end
            S_DROP:
            begin
                ctl_op = OP_DROP;
                if (found)
                    count_next = count_reg - CNT_W'(1);
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (count_reg == CNT_W'(QUEUE_DEPTH))
                        e_status = STATUS_FULL;
                    else
                    begin
                        ctl_op     = OP_INSERT;
                        count_next = count_reg + CNT_W'(1);
                        e_cnt      = count_reg + CNT_W'(1);
                        e_head     = suffix_chain[0] ? cell_deadline[0] : new_dl_reg;
                    end
                end
            end
            S_REMOVE:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (found)
                    begin
                        ctl_op     = OP_DROP;
                        count_next = count_reg - CNT_W'(1);
                        e_cnt      = count_reg - CNT_W'(1);
                        e_head     = seen_chain[1] ? cell_deadline[1] : cell_deadline[0];
                    end
                    else
                        e_status = STATUS_NOT_FOUND;
                end
            end
            S_REAP:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (count_reg != '0)
                    begin
                        ctl_op     = OP_POP;
                        count_next = count_reg - CNT_W'(1);
                        e_cnt      = count_reg - CNT_W'(1);
                        e_head     = cell_deadline[1];
                        e_conn     = cell_conn[0];
                        e_flag     = 1'b1;
                    end
                    else
                        e_status = STATUS_EMPTY;
                end
            end
            S_TICK:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (pop_cond)
                    begin
                        ctl_op       = OP_POP;
                        count_next   = count_reg - CNT_W'(1);
                        pop_cnt_next = pop_cnt_reg + POP_W'(1);
                        e_cnt        = count_reg - CNT_W'(1);
                        e_head       = cell_deadline[1];
                        e_conn       = cell_conn[0];
                        e_flag       = 1'b1;
                        e_last       = !next_cond;
                        if (!next_cond)
                            state_next = S_IDLE;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_NOP:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            time_wait_reg <= '0;
            fin_wait_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_addr)
                    REG_TIME_WAIT: time_wait_reg <= cfg_data;
                    REG_FIN_WAIT:  fin_wait_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_conn_reg <= req_conn_next;
        now_reg      <= now_next;
        new_dl_reg   <= new_dl_next;
        pop_cnt_reg  <= pop_cnt_next;
        if (emit)
        begin
            out_conn_reg     <= e_conn;
            out_flag_reg     <= e_flag;
            out_last_reg     <= e_last;
            out_status_reg   <= e_status;
            out_armed_reg    <= (e_cnt != '0);
            out_deadline_reg <= (e_cnt != '0) ? e_head : '0;
            out_count_reg    <= e_cnt;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_flag_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = OUT_W'({out_count_reg, out_deadline_reg, out_armed_reg,
                               out_status_reg, out_conn_reg});

endmodule

// ===== hw/rtl/dstq_checker.sv =====
// ----------------------------------------------------------------------------
// dstq_checker
// port-level checks on the result stream of the timeout queue
// ----------------------------------------------------------------------------
`include "deadline_sorted_timeout_queue_macros.svh"

module dstq_checker
    import dstq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int CONN_ID_BITS = DEF_CONN_ID_BITS
)
(
    input logic clk,
    input logic rst_n,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tuser,
    input logic m_tlast,
    input logic [(((CONN_ID_BITS + STATUS_W + 1 + TIME_W + $clog2(QUEUE_DEPTH + 1))
                  + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CONN_ID_BITS-1:0] conn;
    logic                    armed;
    logic [TIME_W-1:0]       deadline;
    logic [CNT_W-1:0]        count;

    assign conn     = m_tdata[CONN_ID_BITS-1:0];
    assign armed    = m_tdata[CONN_ID_BITS + STATUS_W];
    assign deadline = m_tdata[CONN_ID_BITS + STATUS_W + 1 +: TIME_W];
    assign count    = m_tdata[CONN_ID_BITS + STATUS_W + 1 + TIME_W +: CNT_W];

    `DSTQ_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `DSTQ_ASSERT_SAME(a_conn_zero, clk, rst_n, m_tvalid && !m_tuser, conn == '0)
    `DSTQ_ASSERT_SAME(a_armed_count, clk, rst_n, m_tvalid, armed == (count != '0))
    `DSTQ_ASSERT_SAME(a_disarmed_zero, clk, rst_n, m_tvalid && !armed, deadline == '0)
    `DSTQ_ASSERT_SAME(a_count_max, clk, rst_n, m_tvalid, count <= CNT_W'(QUEUE_DEPTH))

endmodule

bind deadline_sorted_timeout_queue dstq_checker #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .CONN_ID_BITS (CONN_ID_BITS)
) u_dstq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tdata  (m_tdata)
);
